/* src/spmq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strict-priority multi-queue package
// Shared types, status codes and default sizes for the scheduler blocks.
// ----------------------------------------------------------------------------
package spmq_pkg;

  // default sizes
  localparam int NUM_LEVELS_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MSG_BITS_DEF    = 32;

  // command queue between front and back
  localparam int CMD_FIFO_DEPTH = 4;

  // levels in use after reset
  localparam logic [3:0] LEVELS_RESET = 4'd8;

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // response status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_BAD_PRIORITY = 2'd1;
  localparam logic [1:0] ST_EMPTY        = 2'd2;
  localparam logic [1:0] ST_FULL         = 2'd3;

  // request beat
  typedef struct packed {
    logic        req_type;
    logic [2:0]  priority_req;
    logic [31:0] write_data;
  } req_t;

  // response beat
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_data;
  } rsp_t;

  // resolved command passed from front to back
  typedef struct packed {
    logic       ram_wr;
    logic       ram_rd;
    logic [1:0] status;
  } cmd_ctl_t;

endpackage

/* src/spmq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered and held without rd_en.
// ----------------------------------------------------------------------------
module spmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/spmq_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler front end
// Takes request beats, keeps per-level pointers and counts, resolves status
// and store address, and hands a command to the back end.
// ----------------------------------------------------------------------------
module spmq_front #(
  parameter int NUM_LEVELS  = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int MSG_BITS    = 32
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic [3:0]                                          levels_in_use,
  input  logic                                                req_valid,
  output logic                                                req_stall,
  input  spmq_pkg::req_t                                      req,
  input  logic                                                cmd_full,
  output logic                                                cmd_valid,
  output spmq_pkg::cmd_ctl_t                                  cmd_ctl,
  output logic [$clog2(NUM_LEVELS)+$clog2(QUEUE_DEPTH)-1:0]   cmd_addr,
  output logic [MSG_BITS-1:0]                                 cmd_data
);

  import spmq_pkg::*;

  localparam int LW = $clog2(NUM_LEVELS);
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_POS = PW'(QUEUE_DEPTH - 1);

  logic [PW-1:0] head  [NUM_LEVELS];
  logic [PW-1:0] tail  [NUM_LEVELS];
  logic [CW-1:0] count [NUM_LEVELS];

  logic          accept;
  logic          prio_ok;
  logic [LW-1:0] wr_lvl;
  logic [LW-1:0] rd_lvl;
  logic          found;
  logic [PW-1:0] wr_pos;
  logic [PW-1:0] rd_pos;

  // accept whenever the command queue has room
  assign req_stall = cmd_full;
  assign accept    = req_valid && !cmd_full;
  assign cmd_valid = accept;
  assign cmd_data  = MSG_BITS'(req.write_data);

  // write level checks against the active count
  assign prio_ok = ({1'b0, req.priority_req} < levels_in_use) &&
                   (int'(req.priority_req) < NUM_LEVELS);
  assign wr_lvl  = LW'(req.priority_req);
  assign wr_pos  = tail[wr_lvl];
  assign rd_pos  = head[rd_lvl];

  // lowest-numbered active level holding a word
  always_comb begin
    found  = 1'b0;
    rd_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if ((4'(i) < levels_in_use) && (count[i] != '0)) begin
        found  = 1'b1;
        rd_lvl = LW'(i);
      end
    end
  end

  // resolve the command
  always_comb begin
    cmd_ctl  = '{ram_wr: 1'b0, ram_rd: 1'b0, status: ST_OK};
    cmd_addr = {rd_lvl, rd_pos};
    if (req.req_type == REQ_WRITE) begin
      cmd_addr = {wr_lvl, wr_pos};
      if (!prio_ok) begin
        cmd_ctl.status = ST_BAD_PRIORITY;
      end else if (count[wr_lvl] == FULL_CNT) begin
        cmd_ctl.status = ST_FULL;
      end else begin
        cmd_ctl.ram_wr = 1'b1;
      end
    end else begin
      if (found) begin
        cmd_ctl.ram_rd = 1'b1;
      end else begin
        cmd_ctl.status = ST_EMPTY;
      end
    end
  end

  // pointer and count bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else if (accept) begin
      if (cmd_ctl.ram_wr) begin
        tail[wr_lvl]  <= (wr_pos == LAST_POS) ? '0 : wr_pos + 1'b1;
        count[wr_lvl] <= count[wr_lvl] + 1'b1;
      end
      if (cmd_ctl.ram_rd) begin
        head[rd_lvl]  <= (rd_pos == LAST_POS) ? '0 : rd_pos + 1'b1;
        count[rd_lvl] <= count[rd_lvl] - 1'b1;
      end
    end
  end

endmodule

/* src/spmq_cmd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Short register FIFO decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module spmq_cmd_fifo #(
  parameter int WIDTH = 40
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             nonempty
);

  import spmq_pkg::*;

  localparam int PTR = $clog2(CMD_FIFO_DEPTH);
  localparam int CNT = $clog2(CMD_FIFO_DEPTH + 1);
  localparam logic [CNT-1:0] FULL_CNT = CNT'(CMD_FIFO_DEPTH);
  localparam logic [PTR-1:0] LAST_PTR = PTR'(CMD_FIFO_DEPTH - 1);

  logic [WIDTH-1:0] entry [CMD_FIFO_DEPTH];
  logic [PTR-1:0]   wr_ptr;
  logic [PTR-1:0]   rd_ptr;
  logic [CNT-1:0]   fill;

  assign full     = (fill == FULL_CNT);
  assign nonempty = (fill != '0);
  assign pop_data = entry[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* src/spmq_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler back end
// Carries out store writes and reads in command order and registers the
// response beat.
// ----------------------------------------------------------------------------
module spmq_back #(
  parameter int ADDR_BITS = 7,
  parameter int MSG_BITS  = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_pop,
  input  spmq_pkg::cmd_ctl_t       cmd_ctl,
  input  logic [ADDR_BITS-1:0]     cmd_addr,
  input  logic [MSG_BITS-1:0]      cmd_data,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output spmq_pkg::rsp_t           rsp
);

  import spmq_pkg::*;

  localparam int RAM_DEPTH = 1 << ADDR_BITS;

  logic                a_valid;
  cmd_ctl_t            a_ctl;
  logic                out_free;
  logic                a_move;
  logic                a_free;
  logic [MSG_BITS-1:0] rd_data;

  // stage handshakes
  assign out_free = !rsp_valid || !rsp_stall;
  assign a_move   = a_valid && out_free;
  assign a_free   = !a_valid || a_move;
  assign cmd_pop  = cmd_valid && a_free;

  // message store
  spmq_ram #(
    .WIDTH (MSG_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd_pop && cmd_ctl.ram_wr),
    .wr_addr (cmd_addr),
    .wr_data (cmd_data),
    .rd_en   (cmd_pop && cmd_ctl.ram_rd),
    .rd_addr (cmd_addr),
    .rd_data (rd_data)
  );

  // valid bits of the access stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid <= cmd_pop;
      end
      if (out_free) begin
        rsp_valid <= a_valid;
      end
    end
  end

  // payload of the access stage and output register
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      a_ctl <= cmd_ctl;
    end
    if (a_move) begin
      rsp.status    <= a_ctl.status;
      rsp.read_data <= a_ctl.ram_rd ? 32'(rd_data) : '0;
    end
  end

endmodule

/* src/strict_priority_multi_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strict-priority multi-queue
// One FIFO per priority level; reads serve the lowest-numbered active level.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries write or read requests;
//   every request gives exactly one beat on the rsp channel (rsp_valid /
//   rsp_stall / rsp) with a status and, for a successful read, the word.
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes levels_in_use;
//   cfg_ready is always high, write it only while no request is in flight.
// Path: request beat -> command queue -> access stage -> output register.
// Throughput: one request per cycle while req_stall is low; the per-level count
//   registers resolve each request in its accept cycle and the store has one
//   write and one read port used by a single command per cycle.
// Reset: all queues empty, levels_in_use set to 8, no response pending.
// Receiver stall: the output register, the access stage and the four-entry
//   command queue fill up, then req_stall rises until beats drain.
// ----------------------------------------------------------------------------
module strict_priority_multi_queue #(
  parameter int NUM_LEVELS  = spmq_pkg::NUM_LEVELS_DEF,
  parameter int QUEUE_DEPTH = spmq_pkg::QUEUE_DEPTH_DEF,
  parameter int MSG_BITS    = spmq_pkg::MSG_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  spmq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output spmq_pkg::rsp_t rsp,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [3:0]     cfg_data
);

  import spmq_pkg::*;

  localparam int AW = $clog2(NUM_LEVELS) + $clog2(QUEUE_DEPTH);
  localparam int CTL_BITS = $bits(cmd_ctl_t);
  localparam int CMD_BITS = CTL_BITS + AW + MSG_BITS;

  logic [3:0]          levels_in_use;
  logic                cmd_push;
  logic                cmd_full;
  logic                cmd_pop;
  logic                cmd_nonempty;
  cmd_ctl_t            push_ctl;
  logic [AW-1:0]       push_addr;
  logic [MSG_BITS-1:0] push_data;
  logic [CMD_BITS-1:0] pop_word;
  cmd_ctl_t            pop_ctl;
  logic [AW-1:0]       pop_addr;
  logic [MSG_BITS-1:0] pop_data;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      levels_in_use <= LEVELS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      levels_in_use <= cfg_data;
    end
  end

  // front end: accept and resolve
  spmq_front #(
    .NUM_LEVELS  (NUM_LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MSG_BITS    (MSG_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .levels_in_use (levels_in_use),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req           (req),
    .cmd_full      (cmd_full),
    .cmd_valid     (cmd_push),
    .cmd_ctl       (push_ctl),
    .cmd_addr      (push_addr),
    .cmd_data      (push_data)
  );

  // command queue
  spmq_cmd_fifo #(
    .WIDTH (CMD_BITS)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data ({push_ctl, push_addr, push_data}),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (pop_word),
    .nonempty  (cmd_nonempty)
  );

  assign {pop_ctl, pop_addr, pop_data} = pop_word;

  // back end: store access and response
  spmq_back #(
    .ADDR_BITS (AW),
    .MSG_BITS  (MSG_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_nonempty),
    .cmd_pop   (cmd_pop),
    .cmd_ctl   (pop_ctl),
    .cmd_addr  (pop_addr),
    .cmd_data  (pop_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // no response left over from before reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // front never pushes into a full command queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("command pushed while queue full");

  // back only pops a queued command
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_nonempty)
    else $error("command popped from empty queue");

  // a word only comes back with an ok status
  a_data_only_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.read_data != '0)) |-> (rsp.status == ST_OK))
    else $error("read data on a failed request");

endmodule
